// ----- rtl/core/bdl_pkg.sv -----
// shared types and constants for the button debounce and long-press unit
package bdl_pkg;

  // field and register widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgActiveLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongPressMs = 2'd2;

  // reset values of the registers
  localparam logic           ActiveLowRst   = 1'b1;
  localparam logic [MsW-1:0] DebounceMsRst  = 16'd30;
  localparam logic [MsW-1:0] LongPressMsRst = 16'd2000;

  // button states
  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_DEB_PRESS    = 3'd1,
    ST_PRESSED      = 3'd2,
    ST_LONG_PRESSED = 3'd3,
    ST_DEB_RELEASE  = 3'd4
  } bdl_state_t;

  // machine context carried from word to word
  typedef struct packed {
    bdl_state_t       state;
    logic [TimeW-1:0] enter_time;
    logic             long_done;
  } bdl_ctx_t;

  // configuration registers
  typedef struct packed {
    logic           active_low;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] long_press_ms;
  } bdl_cfg_t;

  // one result word
  typedef struct packed {
    logic release_res;
    logic long_press;
    logic short_press;
    logic is_pressed;
  } bdl_res_t;

endpackage

// ----- rtl/core/bdl_step.sv -----
// next-state and event logic for one scan sample
module bdl_step (
  input  bdl_pkg::bdl_cfg_t               cfg,
  input  bdl_pkg::bdl_ctx_t               ctx,
  input  logic                            raw_level,
  input  logic [bdl_pkg::TimeW-1:0]       now_ms,
  output bdl_pkg::bdl_ctx_t               ctx_next,
  output bdl_pkg::bdl_res_t               res
);
  import bdl_pkg::*;

  logic             pressed;
  logic [TimeW-1:0] elapsed;
  logic             deb_done;
  logic             hold_done;

  // polarity qualification and wrapping elapsed time
  assign pressed   = cfg.active_low ? ~raw_level : raw_level;
  assign elapsed   = now_ms - ctx.enter_time;
  assign deb_done  = elapsed >= {{(TimeW-MsW){1'b0}}, cfg.debounce_ms};
  assign hold_done = elapsed >= {{(TimeW-MsW){1'b0}}, cfg.long_press_ms};

  // state transitions and events
  always_comb begin
    ctx_next        = ctx;
    res.short_press = 1'b0;
    res.long_press  = 1'b0;
    res.release_res = 1'b0;
    case (ctx.state)
      ST_DEB_PRESS: begin
        if (!pressed) begin
          ctx_next.state = ST_IDLE;
        end else if (deb_done) begin
          ctx_next.state      = ST_PRESSED;
          ctx_next.enter_time = now_ms;
          ctx_next.long_done  = 1'b0;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          ctx_next.state      = ST_DEB_RELEASE;
          ctx_next.enter_time = now_ms;
        end else if (!ctx.long_done && hold_done) begin
          ctx_next.state     = ST_LONG_PRESSED;
          ctx_next.long_done = 1'b1;
          res.long_press     = 1'b1;
        end
      end
      ST_LONG_PRESSED: begin
        if (!pressed) begin
          ctx_next.state      = ST_DEB_RELEASE;
          ctx_next.enter_time = now_ms;
        end
      end
      ST_DEB_RELEASE: begin
        // a bounce goes back without restarting the entry time
        if (pressed) begin
          ctx_next.state = ctx.long_done ? ST_LONG_PRESSED : ST_PRESSED;
        end else if (deb_done) begin
          ctx_next.state  = ST_IDLE;
          res.release_res = 1'b1;
          res.short_press = ~ctx.long_done;
        end
      end
      default: begin
        // idle, and unused codes behave as idle
        if (pressed) begin
          ctx_next.state      = ST_DEB_PRESS;
          ctx_next.enter_time = now_ms;
        end else begin
          ctx_next.state = ST_IDLE;
        end
      end
    endcase
    // pressed level after this sample
    res.is_pressed = (ctx_next.state == ST_PRESSED) ||
                     (ctx_next.state == ST_LONG_PRESSED);
  end

endmodule

// ----- rtl/core/button_debounce_long_press_unit.sv -----
// button debouncer with long-press detection, stream in and out
// path: an accepted input word passes through the input register and then the result register onto m_tdata
// throughput: one word per cycle unless the output stalls; the input register and
// result register are separated by one pass of the state machine compare and update
// logic; s_tready drops only while both registers hold a word and m_tready is low
// reset: rst clears the machine to idle, entry time and long-press flag to zero,
// empties both registers and loads the register defaults 1, 30 and 2000
module button_debounce_long_press_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // raw_level [0], now_ms [32:1], zero [39:33]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // is_pressed [0], short_press [1], long_press [2],
                                 // release_res [3], zero [7:4]
);
  import bdl_pkg::*;

  bdl_cfg_t         cfg;
  bdl_ctx_t         ctx;
  bdl_ctx_t         ctx_next;
  bdl_res_t         res_next;
  bdl_res_t         res;
  logic             in_valid;
  logic             in_level;
  logic [TimeW-1:0] in_now;
  logic             advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low    <= ActiveLowRst;
      cfg.debounce_ms   <= DebounceMsRst;
      cfg.long_press_ms <= LongPressMsRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgActiveLow:   cfg.active_low    <= cfg_data[0];
        CfgDebounceMs:  cfg.debounce_ms   <= cfg_data;
        CfgLongPressMs: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // a held word moves on when the result register is free or being taken
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
      in_now   <= s_tdata[TimeW:1];
    end
  end

  // state machine logic
  bdl_step u_step (
    .cfg       (cfg),
    .ctx       (ctx),
    .raw_level (in_level),
    .now_ms    (in_now),
    .ctx_next  (ctx_next),
    .res       (res_next)
  );

  // machine context
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= ST_IDLE;
      ctx.enter_time <= '0;
      ctx.long_done  <= 1'b0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {4'b0000, res.release_res, res.long_press, res.short_press,
                    res.is_pressed};

  // a short press only comes with a release
  a_short_with_release: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.short_press |-> res_next.release_res)
    else $error("short press without release");

  // a confirmed release leaves the machine idle
  a_release_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.release_res |=> ctx.state == ST_IDLE && !res.is_pressed)
    else $error("release did not return to idle");

  // a long-press event marks the press as long
  a_long_marks_done: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.long_press |=> ctx.long_done && ctx.state == ST_LONG_PRESSED)
    else $error("long press not recorded");

  // the context only changes when a word is processed
  a_ctx_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ctx))
    else $error("context changed without a word");

endmodule

// ----- bench/tb_button_debounce_long_press_unit.sv -----
// testbench for the button debounce and long-press unit: directed and random scan words
module tb_button_debounce_long_press_unit;
  import bdl_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldOff     = 200;
  localparam int unsigned DrainCycles = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // raw_level [0], now_ms [32:1], zero [39:33]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;        // is_pressed [0], short_press [1], long_press [2],
                               // release_res [3], zero [7:4]

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_debounce_long_press_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // shadow copy of the registers and the button machine
  logic             pol_low   = ActiveLowRst;
  logic [MsW-1:0]   settle_ms = DebounceMsRst;
  logic [MsW-1:0]   hold_ms   = LongPressMsRst;
  bdl_state_t       btn_st    = ST_IDLE;
  logic [TimeW-1:0] entry_ms  = '0;
  logic             long_fired = 1'b0;

  // events still owed by the block, oldest first
  bdl_res_t         event_q[$];
  bdl_res_t         got_ev;
  bdl_res_t         want_ev;
  int unsigned      fails = 0;
  int unsigned      reported = 0;
  int unsigned      scans_sent = 0;
  int unsigned      quiet_cycles = 0;
  logic             idle_on = 1'b1;
  logic             stall_req = 1'b0;
  logic [TimeW-1:0] clock_ms = '0;

  // next state and events of the button machine for one scan word
  function automatic bdl_res_t button_events(logic lvl, logic [TimeW-1:0] t);
    logic             down;
    logic [TimeW-1:0] held;
    bdl_res_t         ev;
    down = pol_low ? !lvl : lvl;
    held = t - entry_ms;
    ev = '0;
    case (btn_st)
      ST_DEB_PRESS: begin
        if (!down) begin
          btn_st = ST_IDLE;
        end else if (held >= {16'd0, settle_ms}) begin
          btn_st = ST_PRESSED;
          entry_ms = t;
          long_fired = 1'b0;
        end
      end
      ST_PRESSED: begin
        if (!down) begin
          btn_st = ST_DEB_RELEASE;
          entry_ms = t;
        end else if (!long_fired && held >= {16'd0, hold_ms}) begin
          long_fired = 1'b1;
          btn_st = ST_LONG_PRESSED;
          ev.long_press = 1'b1;
        end
      end
      ST_LONG_PRESSED: begin
        if (!down) begin
          btn_st = ST_DEB_RELEASE;
          entry_ms = t;
        end
      end
      ST_DEB_RELEASE: begin
        // a bounce goes back without touching the entry time
        if (down) begin
          btn_st = long_fired ? ST_LONG_PRESSED : ST_PRESSED;
        end else if (held >= {16'd0, settle_ms}) begin
          btn_st = ST_IDLE;
          ev.release_res = 1'b1;
          ev.short_press = !long_fired;
        end
      end
      default: begin
        if (down) begin
          btn_st = ST_DEB_PRESS;
          entry_ms = t;
        end else begin
          btn_st = ST_IDLE;
        end
      end
    endcase
    ev.is_pressed = (btn_st == ST_PRESSED || btn_st == ST_LONG_PRESSED);
    return ev;
  endfunction

  // offer one scan word, with an optional gap before it
  task automatic send_scan(input logic lvl, input logic [TimeW-1:0] t);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, t, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    event_q.push_back(button_events(lvl, t));
    scans_sent++;
  endtask

  // wait until every result is in and the pipeline is empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CfgActiveLow:   pol_low   = val[0];
      CfgDebounceMs:  settle_ms = val;
      CfgLongPressMs: hold_ms   = val;
      default: ;
    endcase
  endtask

  // drain, then load all three registers
  task automatic reconfigure(input logic pol, input logic [MsW-1:0] deb,
                             input logic [MsW-1:0] lng);
    settle();
    write_reg(CfgActiveLow, {15'd0, pol});
    write_reg(CfgDebounceMs, deb);
    write_reg(CfgLongPressMs, lng);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // physical button action after dt milliseconds
  task automatic push_btn(input logic down, input int unsigned dt);
    clock_ms += dt;
    send_scan(pol_low ? !down : down, clock_ms);
  endtask

  function automatic int unsigned bounce_dt();
    return (settle_ms > 1) ? $urandom_range(0, (settle_ms - 1) / 2) : 0;
  endfunction

  function automatic int unsigned pick_ms(int unsigned typical);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  // one press with bounces on both edges, short or long hold
  task automatic play_press();
    int unsigned nb;
    int unsigned m;
    logic        go_long;
    nb = $urandom_range(0, 2);
    repeat (nb) begin
      push_btn(1'b1, bounce_dt());
      push_btn(1'b0, bounce_dt());
    end
    push_btn(1'b1, bounce_dt());
    push_btn(1'b1, settle_ms + $urandom_range(0, 2));
    go_long = 1'($urandom_range(0, 1));
    m = $urandom_range(1, 3);
    repeat (m) begin
      if (go_long)
        push_btn(1'b1, hold_ms / m + $urandom_range(0, 3));
      else
        push_btn(1'b1, (hold_ms > m) ? $urandom_range(0, (hold_ms - 1) / (m + 1)) : 0);
    end
    nb = $urandom_range(0, 2);
    repeat (nb) begin
      push_btn(1'b0, bounce_dt());
      push_btn(1'b1, bounce_dt());
    end
    push_btn(1'b0, bounce_dt());
    push_btn(1'b0, settle_ms + $urandom_range(0, 2));
    push_btn(1'b0, $urandom_range(0, 50));
  endtask

  // random level at a random or jumping time
  task automatic scan_noise();
    case ($urandom_range(0, 3))
      0:       clock_ms = $urandom;
      1:       clock_ms -= $urandom_range(0, 100);
      default: clock_ms += $urandom_range(0, 3 * settle_ms + 10);
    endcase
    send_scan(1'($urandom_range(0, 1)), clock_ms);
  endtask

  task automatic mixed_scans(input int unsigned count);
    int unsigned stop_at;
    stop_at = scans_sent + count;
    while (scans_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0)
        play_press();
      else
        repeat ($urandom_range(1, 5)) scan_noise();
    end
  endtask

  // reset values: bounces, long press with release bounce, short press, time wrap
  task automatic test_default_timing();
    logic [TimeW-1:0] t0;
    t0 = 32'hFFFF_FF00;
    send_scan(1'b1, 32'd0);
    send_scan(1'b0, t0);
    send_scan(1'b0, t0 + 10);
    send_scan(1'b1, t0 + 12);
    send_scan(1'b0, t0 + 20);
    send_scan(1'b0, t0 + 50);
    send_scan(1'b0, t0 + 500);
    send_scan(1'b0, t0 + 2049);
    send_scan(1'b0, t0 + 2050);
    send_scan(1'b0, t0 + 3000);
    send_scan(1'b1, t0 + 3010);
    send_scan(1'b0, t0 + 3020);
    send_scan(1'b1, t0 + 3030);
    send_scan(1'b1, t0 + 3060);
    // release bounce keeps the entry time, so the hold counts from 140
    send_scan(1'b0, 32'd100);
    send_scan(1'b0, 32'd130);
    send_scan(1'b1, 32'd140);
    send_scan(1'b0, 32'd150);
    send_scan(1'b0, 32'd2139);
    send_scan(1'b0, 32'd2140);
    send_scan(1'b1, 32'd2200);
    send_scan(1'b1, 32'd2230);
    // short press across the top of the timer
    send_scan(1'b0, 32'hFFFF_FFFF);
    send_scan(1'b0, 32'd29);
    send_scan(1'b1, 32'd40);
    send_scan(1'b1, 32'd70);
  endtask

  // zero debounce time, hold time zero and then one, active-high pin
  task automatic test_zero_times();
    reconfigure(1'b0, 16'd0, 16'd0);
    send_scan(1'b1, 32'd5);
    send_scan(1'b1, 32'd5);
    send_scan(1'b1, 32'd5);
    send_scan(1'b0, 32'd5);
    send_scan(1'b0, 32'd5);
    reconfigure(1'b0, 16'd0, 16'd1);
    send_scan(1'b1, 32'd9);
    send_scan(1'b1, 32'd9);
    send_scan(1'b0, 32'd9);
    send_scan(1'b0, 32'd9);
  endtask

  // largest times, and a timer that steps backwards
  task automatic test_max_times();
    reconfigure(1'b1, 16'hFFFF, 16'hFFFF);
    send_scan(1'b0, 32'd0);
    send_scan(1'b0, 32'd65534);
    send_scan(1'b0, 32'd65535);
    send_scan(1'b0, 32'd131069);
    send_scan(1'b0, 32'd131070);
    send_scan(1'b1, 32'd131071);
    send_scan(1'b1, 32'd196605);
    send_scan(1'b1, 32'd196606);
    send_scan(1'b0, 32'd1000);
    send_scan(1'b0, 32'd999);
    send_scan(1'b1, 32'd1000);
    send_scan(1'b1, 32'd66535);
  endtask

  // random presses under the reset register values or a random register setting
  task automatic test_random_presses(input int unsigned count, input logic keep_rst);
    if (keep_rst)
      reconfigure(ActiveLowRst, DebounceMsRst, LongPressMsRst);
    else
      reconfigure(1'($urandom_range(0, 1)), MsW'(pick_ms(100)), MsW'(pick_ms(3000)));
    mixed_scans(count);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_output_stall();
    settle();
    stall_req = 1'b1;
    mixed_scans(40);
  endtask

  // last part: no gaps and no stalls
  task automatic test_back_to_back();
    settle();
    idle_on = 1'b0;
    reconfigure(1'($urandom_range(0, 1)), MsW'(pick_ms(60)), MsW'(pick_ms(500)));
    mixed_scans(250);
  endtask

  // receiver side: random stalls and the requested long hold
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldOff - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest owed events
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_ev = bdl_res_t'(m_tdata[3:0]);
      if (event_q.size() == 0) begin
        fails++;
        if (reported < 10)
          $display("unexpected result word %b", m_tdata);
        reported++;
      end else begin
        want_ev = event_q.pop_front();
        if (got_ev.is_pressed !== want_ev.is_pressed ||
            got_ev.short_press !== want_ev.short_press ||
            got_ev.long_press !== want_ev.long_press ||
            got_ev.release_res !== want_ev.release_res) begin
          fails++;
          if (reported < 10)
            $display("mismatch: expected pressed=%b short=%b long=%b release=%b, %s",
                     want_ev.is_pressed, want_ev.short_press, want_ev.long_press,
                     want_ev.release_res,
                     $sformatf("got pressed=%b short=%b long=%b release=%b",
                               got_ev.is_pressed, got_ev.short_press,
                               got_ev.long_press, got_ev.release_res));
          reported++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_zero_times();
    test_max_times();
    test_random_presses(200, 1'b1);
    repeat (5) test_random_presses(200, 1'b0);
    test_output_stall();
    test_back_to_back();
    settle();
    repeat (10) @(posedge clk);
    if (event_q.size() != 0) fails++;
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
